### hdl/im2col_address_generator_macros.svh
// ----------------------------------------------------------------------------
// im2col address generator assertion macros
// Clocked implication helpers shared by the checker.
// ----------------------------------------------------------------------------
`ifndef IM2COL_ADDRESS_GENERATOR_MACROS_SVH
`define IM2COL_ADDRESS_GENERATOR_MACROS_SVH

// same-cycle implication
`define IAG_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IAG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/iag_pkg.sv
// ----------------------------------------------------------------------------
// iag_pkg
// Widths, register codes and shared structs of the im2col address generator.
// ----------------------------------------------------------------------------
package iag_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int CH_W    = 11;  // channel count register
  localparam int IMG_W   = 9;   // image height / width register
  localparam int KER_W   = 5;   // kernel height / width register
  localparam int BYTE_W  = 8;   // pad, stride, dilation per direction
  localparam int OD_W    = 10;  // derived output size
  localparam int NUM_W   = 10;  // non-negative size numerator
  localparam int NUM_S_W = 14;  // signed size numerator
  localparam int SRC_W   = 11;  // signed source row / column
  localparam int OFF_W   = 10;  // kernel offset (index times dilation)
  localparam int ADDR_W  = 26;
  localparam int CROW_W  = 18;
  localparam int CCOL_W  = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNEL_COUNT  = 3'd0,
    REG_IMAGE_HEIGHT   = 3'd1,
    REG_IMAGE_WIDTH    = 3'd2,
    REG_KERNEL_HEIGHT  = 3'd3,
    REG_KERNEL_WIDTH   = 3'd4,
    REG_PAD_SIZES      = 3'd5,
    REG_STRIDE_SIZES   = 3'd6,
    REG_DILATION_SIZES = 3'd7
  } cfg_reg_t;

  localparam logic [CH_W-1:0]       RST_CHANNEL_COUNT  = 11'd1;
  localparam logic [IMG_W-1:0]      RST_IMAGE_HEIGHT   = 9'd8;
  localparam logic [IMG_W-1:0]      RST_IMAGE_WIDTH    = 9'd8;
  localparam logic [KER_W-1:0]      RST_KERNEL_HEIGHT  = 5'd3;
  localparam logic [KER_W-1:0]      RST_KERNEL_WIDTH   = 5'd3;
  localparam logic [CFG_DATA_W-1:0] RST_PAD_SIZES      = 16'd0;
  localparam logic [CFG_DATA_W-1:0] RST_STRIDE_SIZES   = 16'h0101;
  localparam logic [CFG_DATA_W-1:0] RST_DILATION_SIZES = 16'h0101;

  // derived geometry handed from the config unit to the walker
  typedef struct packed {
    logic [CH_W-1:0]   eff_c;
    logic [IMG_W-1:0]  eff_h;
    logic [IMG_W-1:0]  eff_w;
    logic [KER_W-1:0]  eff_kh;
    logic [KER_W-1:0]  eff_kw;
    logic [BYTE_W-1:0] pad_v;
    logic [BYTE_W-1:0] pad_h;
    logic [BYTE_W-1:0] str_v;
    logic [BYTE_W-1:0] str_h;
    logic [BYTE_W-1:0] dil_v;
    logic [BYTE_W-1:0] dil_h;
    logic [ADDR_W-1:0] plane;
    logic [OD_W-1:0]   out_h;
    logic [OD_W-1:0]   out_w;
    logic              cfg_err;
  } geom_t;

  typedef struct packed {
    logic [ADDR_W-1:0] element_address;
    logic              is_padding;
    logic [CROW_W-1:0] column_row;
    logic [CCOL_W-1:0] column_col;
    logic              last_element;
    logic              config_error;
  } result_t;

endpackage

### hdl/iag_item_if.sv
// ----------------------------------------------------------------------------
// iag_item_if
// Input channel: one restart flag per transaction.
// ----------------------------------------------------------------------------
interface iag_item_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

### hdl/iag_result_if.sv
// ----------------------------------------------------------------------------
// iag_result_if
// Result channel: one column-matrix element per transaction.
// ----------------------------------------------------------------------------
interface iag_result_if;
  import iag_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] element_address;
  logic              is_padding;
  logic [CROW_W-1:0] column_row;
  logic [CCOL_W-1:0] column_col;
  logic              last_element;
  logic              config_error;

  modport source (output valid, output element_address, output is_padding,
                  output column_row, output column_col, output last_element,
                  output config_error, input ready);
  modport sink (input valid, input element_address, input is_padding,
                input column_row, input column_col, input last_element,
                input config_error, output ready);
endinterface

### hdl/im2col_address_generator.sv
// ----------------------------------------------------------------------------
// im2col_address_generator
// Walks the im2col column matrix with padding, stride and dilation.
// ----------------------------------------------------------------------------
// Each item transaction on "item" yields exactly one result transaction on
// "result": the element at the current position (or at the first element when
// restart is set), after which the position moves on by one. The walk order
// is channel, kernel row, kernel column, output row, output column, outermost
// first, and wraps to the start after the last element (last_element = 1).
// Throughput is one element per clock unless the skid entry is full or the
// geometry is being derived: the position counters and incremental source
// row/column registers feed one 9x9 multiply plus add for the address,
// straight into a two-entry output buffer, so an item is still taken while
// one result is stalled downstream. After reset and after every register
// write the block derives output height and width with two bit-serial
// dividers; item ready stays low while it prepares, divides, sees the
// dividers done and finishes. A write also returns the walk to the first
// element. When either derived output size is not positive, every result
// carries config_error = 1 with all other fields zero and the walk holds.
// ----------------------------------------------------------------------------
module im2col_address_generator #(
  parameter int MAX_DIM      = 256,
  parameter int MAX_CHANNELS = 1024,
  parameter int MAX_KERNEL   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  iag_item_if.sink                      item,
  iag_result_if.source                  result,
  input  logic                          write_enable,
  input  logic [iag_pkg::CFG_IDX_W-1:0]  register_index,
  input  logic [iag_pkg::CFG_DATA_W-1:0] write_data
);
  import iag_pkg::*;

  geom_t   geom;
  result_t res;
  logic    cfg_busy;
  logic    cfg_load;
  logic    buf_space;
  logic    fire;

  // register file and geometry derivation
  iag_cfg #(
    .MAX_DIM      (MAX_DIM),
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_KERNEL   (MAX_KERNEL)
  ) u_cfg (
    .clk            (clk),
    .rst            (rst),
    .write_enable   (write_enable),
    .register_index (register_index),
    .write_data     (write_data),
    .geom           (geom),
    .busy           (cfg_busy),
    .load           (cfg_load)
  );

  // accept while the skid entry is free and the geometry is settled
  assign item.ready = buf_space && !cfg_busy;
  assign fire       = item.valid && item.ready;

  // position counters; the result is formed in the cycle of acceptance
  iag_walk u_walk (
    .clk     (clk),
    .rst     (rst),
    .load    (cfg_load),
    .step    (fire),
    .restart (item.restart),
    .geom    (geom),
    .res     (res)
  );

  // result register and skid entry
  iag_obuf u_obuf (
    .clk    (clk),
    .rst    (rst),
    .push   (fire),
    .data   (res),
    .space  (buf_space),
    .result (result)
  );
endmodule

### hdl/iag_div.sv
// ----------------------------------------------------------------------------
// iag_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module iag_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [iag_pkg::NUM_W-1:0]  numer,
  input  logic [iag_pkg::BYTE_W-1:0] denom,
  output logic                      busy,
  output logic [iag_pkg::NUM_W-1:0]  quot
);
  import iag_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  shift;
  logic [BYTE_W-1:0] rem;
  logic [BYTE_W-1:0] dvs;
  logic [CNT_W-1:0]  cnt;
  logic [BYTE_W:0]   trial;
  logic              fits;

  assign trial = {rem, shift[NUM_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NUM_W);
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      busy <= cnt != CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shift <= numer;
      rem   <= '0;
      dvs   <= denom;
      quot  <= '0;
    end else if (busy) begin
      shift <= {shift[NUM_W-2:0], 1'b0};
      rem   <= fits ? BYTE_W'(trial - {1'b0, dvs}) : trial[BYTE_W-1:0];
      quot  <= {quot[NUM_W-2:0], fits};
    end
  end
endmodule

### hdl/iag_cfg.sv
// ----------------------------------------------------------------------------
// iag_cfg
// Configuration registers and derivation of the walk geometry.
// ----------------------------------------------------------------------------
module iag_cfg #(
  parameter int MAX_DIM      = 256,
  parameter int MAX_CHANNELS = 1024,
  parameter int MAX_KERNEL   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          write_enable,
  input  logic [iag_pkg::CFG_IDX_W-1:0]  register_index,
  input  logic [iag_pkg::CFG_DATA_W-1:0] write_data,
  output iag_pkg::geom_t                geom,
  output logic                          busy,
  output logic                          load
);
  import iag_pkg::*;

  localparam int CH_LIM  = (MAX_CHANNELS < 2047) ? MAX_CHANNELS : 2047;
  localparam int IMG_LIM = (MAX_DIM < 511) ? MAX_DIM : 511;
  localparam int KER_LIM = (MAX_KERNEL < 31) ? MAX_KERNEL : 31;
  localparam int OUT_LIM = (MAX_DIM < 1023) ? MAX_DIM : 1023;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PREP = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIN  = 4'b1000
  } cfg_state_t;

  cfg_state_t state, state_next;

  logic [CH_W-1:0]       channel_count;
  logic [IMG_W-1:0]      image_height, image_width;
  logic [KER_W-1:0]      kernel_height, kernel_width;
  logic [CFG_DATA_W-1:0] pad_sizes, stride_sizes, dilation_sizes;

  logic [CH_W-1:0]          c_eff;
  logic [IMG_W-1:0]         h_eff, w_eff;
  logic [KER_W-1:0]         kh_eff, kw_eff;
  logic [BYTE_W-1:0]        sv, sh, dv, dh;
  logic [BYTE_W+KER_W-1:0]  span_v, span_h;
  logic signed [NUM_S_W-1:0] num_v, num_h;
  logic [2*IMG_W-1:0]       plane_c;
  logic                     neg_v, neg_h;
  logic                     busy_v, busy_h;
  logic [NUM_W-1:0]         quot_v, quot_h;
  logic [NUM_W:0]           o_v, o_h;
  logic [OD_W-1:0]          out_v, out_h;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count  <= RST_CHANNEL_COUNT;
      image_height   <= RST_IMAGE_HEIGHT;
      image_width    <= RST_IMAGE_WIDTH;
      kernel_height  <= RST_KERNEL_HEIGHT;
      kernel_width   <= RST_KERNEL_WIDTH;
      pad_sizes      <= RST_PAD_SIZES;
      stride_sizes   <= RST_STRIDE_SIZES;
      dilation_sizes <= RST_DILATION_SIZES;
    end else if (write_enable) begin
      case (cfg_reg_t'(register_index))
        REG_CHANNEL_COUNT:  channel_count  <= write_data[CH_W-1:0];
        REG_IMAGE_HEIGHT:   image_height   <= write_data[IMG_W-1:0];
        REG_IMAGE_WIDTH:    image_width    <= write_data[IMG_W-1:0];
        REG_KERNEL_HEIGHT:  kernel_height  <= write_data[KER_W-1:0];
        REG_KERNEL_WIDTH:   kernel_width   <= write_data[KER_W-1:0];
        REG_PAD_SIZES:      pad_sizes      <= write_data;
        REG_STRIDE_SIZES:   stride_sizes   <= write_data;
        REG_DILATION_SIZES: dilation_sizes <= write_data;
        default: ;
      endcase
    end
  end

  // clamp sizes: zero counts as one, saturate at the limits
  always_comb begin
    c_eff  = (channel_count == '0) ? CH_W'(1) :
             (channel_count > CH_W'(CH_LIM)) ? CH_W'(CH_LIM) : channel_count;
    h_eff  = (image_height == '0) ? IMG_W'(1) :
             (image_height > IMG_W'(IMG_LIM)) ? IMG_W'(IMG_LIM) : image_height;
    w_eff  = (image_width == '0) ? IMG_W'(1) :
             (image_width > IMG_W'(IMG_LIM)) ? IMG_W'(IMG_LIM) : image_width;
    kh_eff = (kernel_height == '0) ? KER_W'(1) :
             (kernel_height > KER_W'(KER_LIM)) ? KER_W'(KER_LIM) : kernel_height;
    kw_eff = (kernel_width == '0) ? KER_W'(1) :
             (kernel_width > KER_W'(KER_LIM)) ? KER_W'(KER_LIM) : kernel_width;
    sv = (stride_sizes[15:8] == '0) ? BYTE_W'(1) : stride_sizes[15:8];
    sh = (stride_sizes[7:0] == '0) ? BYTE_W'(1) : stride_sizes[7:0];
    dv = (dilation_sizes[15:8] == '0) ? BYTE_W'(1) : dilation_sizes[15:8];
    dh = (dilation_sizes[7:0] == '0) ? BYTE_W'(1) : dilation_sizes[7:0];
  end

  // numerator: image + 2*pad - (dil*(k-1) + 1)
  assign span_v  = dv * (kh_eff - KER_W'(1));
  assign span_h  = dh * (kw_eff - KER_W'(1));
  assign num_v   = $signed(NUM_S_W'(h_eff)) + $signed(NUM_S_W'({pad_sizes[15:8], 1'b0}))
                 - $signed(NUM_S_W'(span_v)) - $signed(NUM_S_W'(1));
  assign num_h   = $signed(NUM_S_W'(w_eff)) + $signed(NUM_S_W'({pad_sizes[7:0], 1'b0}))
                 - $signed(NUM_S_W'(span_h)) - $signed(NUM_S_W'(1));
  assign plane_c = h_eff * w_eff;

  iag_div u_div_v (
    .clk   (clk),
    .rst   (rst),
    .start (state == ST_PREP),
    .numer (num_v[NUM_W-1:0]),
    .denom (sv),
    .busy  (busy_v),
    .quot  (quot_v)
  );

  iag_div u_div_h (
    .clk   (clk),
    .rst   (rst),
    .start (state == ST_PREP),
    .numer (num_h[NUM_W-1:0]),
    .denom (sh),
    .busy  (busy_h),
    .quot  (quot_h)
  );

  // quotient + 1, zero when the numerator went negative, saturate at the limit
  assign o_v   = {1'b0, quot_v} + (NUM_W+1)'(1);
  assign o_h   = {1'b0, quot_h} + (NUM_W+1)'(1);
  assign out_v = neg_v ? '0 : (o_v > (NUM_W+1)'(OUT_LIM)) ? OD_W'(OUT_LIM) : OD_W'(o_v);
  assign out_h = neg_h ? '0 : (o_h > (NUM_W+1)'(OUT_LIM)) ? OD_W'(OUT_LIM) : OD_W'(o_h);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: state_next = ST_IDLE;
      ST_PREP: state_next = ST_DIV;
      ST_DIV:  if (!busy_v && !busy_h) state_next = ST_FIN;
      ST_FIN:  state_next = ST_IDLE;
      default: state_next = ST_PREP;
    endcase
    if (write_enable) state_next = ST_PREP;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_PREP;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_PREP) begin
      geom.eff_c  <= c_eff;
      geom.eff_h  <= h_eff;
      geom.eff_w  <= w_eff;
      geom.eff_kh <= kh_eff;
      geom.eff_kw <= kw_eff;
      geom.pad_v  <= pad_sizes[15:8];
      geom.pad_h  <= pad_sizes[7:0];
      geom.str_v  <= sv;
      geom.str_h  <= sh;
      geom.dil_v  <= dv;
      geom.dil_h  <= dh;
      geom.plane  <= ADDR_W'(plane_c);
      neg_v       <= num_v[NUM_S_W-1];
      neg_h       <= num_h[NUM_S_W-1];
    end
    if (state == ST_FIN) begin
      geom.out_h   <= out_v;
      geom.out_w   <= out_h;
      geom.cfg_err <= (out_v == '0) || (out_h == '0);
    end
  end

  assign busy = state != ST_IDLE;
  assign load = state == ST_FIN;
endmodule

### hdl/iag_walk.sv
// ----------------------------------------------------------------------------
// iag_walk
// Nested position counters with incremental source coordinates.
// ----------------------------------------------------------------------------
module iag_walk (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic             step,
  input  logic             restart,
  input  iag_pkg::geom_t   geom,
  output iag_pkg::result_t res
);
  import iag_pkg::*;

  logic [CH_W-1:0]   ch, ch_next, cur_ch;
  logic [KER_W-1:0]  kr, kr_next, cur_kr;
  logic [KER_W-1:0]  kc, kc_next, cur_kc;
  logic [OD_W-1:0]   orow, orow_next, cur_orow;
  logic [OD_W-1:0]   ocol, ocol_next, cur_ocol;
  logic [SRC_W-1:0]  src_row, src_row_next, cur_row;   // two's complement
  logic [SRC_W-1:0]  src_col, src_col_next, cur_col;
  logic [OFF_W-1:0]  kr_off, kr_off_next, cur_kr_off;
  logic [OFF_W-1:0]  kc_off, kc_off_next, cur_kc_off;
  logic [ADDR_W-1:0] chan_base, chan_base_next, cur_base;
  logic [CROW_W-1:0] col_row, col_row_next, cur_crow;
  logic [CCOL_W-1:0] col_col, col_col_next, cur_ccol;

  logic [SRC_W-1:0]   row_start, col_start;
  logic               oc_wrap, or_wrap, kc_wrap, kr_wrap, ch_wrap;
  logic               row_in, col_in;
  logic [2*IMG_W-1:0] row_prod;
  logic [OFF_W-1:0]   kr_off_inc, kc_off_inc;

  assign row_start = SRC_W'(0) - SRC_W'(geom.pad_v);
  assign col_start = SRC_W'(0) - SRC_W'(geom.pad_h);

  // restart views the start position in the same cycle
  always_comb begin
    if (restart) begin
      cur_ch = '0; cur_kr = '0; cur_kc = '0; cur_orow = '0; cur_ocol = '0;
      cur_row = row_start; cur_col = col_start;
      cur_kr_off = '0; cur_kc_off = '0;
      cur_base = '0; cur_crow = '0; cur_ccol = '0;
    end else begin
      cur_ch = ch; cur_kr = kr; cur_kc = kc; cur_orow = orow; cur_ocol = ocol;
      cur_row = src_row; cur_col = src_col;
      cur_kr_off = kr_off; cur_kc_off = kc_off;
      cur_base = chan_base; cur_crow = col_row; cur_ccol = col_col;
    end
  end

  assign oc_wrap = ({1'b0, cur_ocol} + (OD_W+1)'(1)) == {1'b0, geom.out_w};
  assign or_wrap = ({1'b0, cur_orow} + (OD_W+1)'(1)) == {1'b0, geom.out_h};
  assign kc_wrap = ({1'b0, cur_kc} + (KER_W+1)'(1)) == {1'b0, geom.eff_kw};
  assign kr_wrap = ({1'b0, cur_kr} + (KER_W+1)'(1)) == {1'b0, geom.eff_kh};
  assign ch_wrap = ({1'b0, cur_ch} + (CH_W+1)'(1)) == {1'b0, geom.eff_c};

  assign kr_off_inc = cur_kr_off + OFF_W'(geom.dil_v);
  assign kc_off_inc = cur_kc_off + OFF_W'(geom.dil_h);

  // advance by one element
  always_comb begin
    ch_next = cur_ch; kr_next = cur_kr; kc_next = cur_kc;
    orow_next = cur_orow; ocol_next = cur_ocol;
    src_row_next = cur_row; src_col_next = cur_col;
    kr_off_next = cur_kr_off; kc_off_next = cur_kc_off;
    chan_base_next = cur_base;
    col_row_next = cur_crow;
    col_col_next = cur_ccol + CCOL_W'(1);
    if (!oc_wrap) begin
      ocol_next    = cur_ocol + OD_W'(1);
      src_col_next = cur_col + SRC_W'(geom.str_h);
    end else begin
      ocol_next = '0;
      if (!or_wrap) begin
        orow_next    = cur_orow + OD_W'(1);
        src_row_next = cur_row + SRC_W'(geom.str_v);
        src_col_next = SRC_W'(cur_kc_off) + col_start;
      end else begin
        orow_next    = '0;
        col_col_next = '0;
        col_row_next = cur_crow + CROW_W'(1);
        if (!kc_wrap) begin
          kc_next      = cur_kc + KER_W'(1);
          kc_off_next  = kc_off_inc;
          src_col_next = SRC_W'(kc_off_inc) + col_start;
          src_row_next = SRC_W'(cur_kr_off) + row_start;
        end else begin
          kc_next      = '0;
          kc_off_next  = '0;
          src_col_next = col_start;
          if (!kr_wrap) begin
            kr_next      = cur_kr + KER_W'(1);
            kr_off_next  = kr_off_inc;
            src_row_next = SRC_W'(kr_off_inc) + row_start;
          end else begin
            kr_next      = '0;
            kr_off_next  = '0;
            src_row_next = row_start;
            if (!ch_wrap) begin
              ch_next        = cur_ch + CH_W'(1);
              chan_base_next = cur_base + geom.plane;
            end else begin
              ch_next        = '0;
              chan_base_next = '0;
              col_row_next   = '0;
            end
          end
        end
      end
    end
  end

  // element at the current position
  assign row_in   = !cur_row[SRC_W-1] && (cur_row[SRC_W-2:0] < {1'b0, geom.eff_h});
  assign col_in   = !cur_col[SRC_W-1] && (cur_col[SRC_W-2:0] < {1'b0, geom.eff_w});
  assign row_prod = cur_row[IMG_W-1:0] * geom.eff_w;

  always_comb begin
    res = '0;
    if (geom.cfg_err) begin
      res.config_error = 1'b1;
    end else begin
      res.is_padding      = !(row_in && col_in);
      res.element_address = res.is_padding ? '0 :
                            cur_base + ADDR_W'(row_prod) + ADDR_W'(cur_col[IMG_W-1:0]);
      res.column_row      = cur_crow;
      res.column_col      = cur_ccol;
      res.last_element    = oc_wrap && or_wrap && kc_wrap && kr_wrap && ch_wrap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || load) begin
      ch <= '0; kr <= '0; kc <= '0; orow <= '0; ocol <= '0;
      src_row <= row_start; src_col <= col_start;
      kr_off <= '0; kc_off <= '0;
      chan_base <= '0; col_row <= '0; col_col <= '0;
    end else if (step && !geom.cfg_err) begin
      ch <= ch_next; kr <= kr_next; kc <= kc_next;
      orow <= orow_next; ocol <= ocol_next;
      src_row <= src_row_next; src_col <= src_col_next;
      kr_off <= kr_off_next; kc_off <= kc_off_next;
      chan_base <= chan_base_next; col_row <= col_row_next; col_col <= col_col_next;
    end
  end
endmodule

### hdl/iag_obuf.sv
// ----------------------------------------------------------------------------
// iag_obuf
// Output register with a skid entry behind it.
// ----------------------------------------------------------------------------
module iag_obuf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  iag_pkg::result_t data,
  output logic             space,
  iag_result_if.source     result
);
  import iag_pkg::*;

  result_t head, skid;
  logic    head_valid, skid_valid;
  logic    pop;

  assign pop   = head_valid && result.ready;
  assign space = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        head_valid <= push;
      end
    end else if (push) begin
      if (head_valid) begin
        skid_valid <= 1'b1;
      end else begin
        head_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      head <= skid_valid ? skid : data;
    end else if (push && !head_valid) begin
      head <= data;
    end
    if (push && head_valid && !pop) begin
      skid <= data;
    end
  end

  assign result.valid           = head_valid;
  assign result.element_address = head.element_address;
  assign result.is_padding      = head.is_padding;
  assign result.column_row      = head.column_row;
  assign result.column_col      = head.column_col;
  assign result.last_element    = head.last_element;
  assign result.config_error    = head.config_error;
endmodule

### hdl/iag_checker.sv
// ----------------------------------------------------------------------------
// iag_checker
// Port-level checks of the im2col address generator.
// ----------------------------------------------------------------------------
`include "im2col_address_generator_macros.svh"

module iag_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       item_ready,
  input logic                       write_enable,
  input logic                       result_valid,
  input logic                       result_ready,
  input logic [iag_pkg::ADDR_W-1:0] element_address,
  input logic                       is_padding,
  input logic [iag_pkg::CROW_W-1:0] column_row,
  input logic [iag_pkg::CCOL_W-1:0] column_col,
  input logic                       last_element,
  input logic                       config_error
);
  import iag_pkg::*;

  `IAG_ASSERT_NEXT(a_result_held, clk, rst, result_valid && !result_ready, result_valid, "result transaction dropped while stalled")

  `IAG_ASSERT_IMPLY(a_err_blank, clk, rst, result_valid && config_error, element_address == '0 && !is_padding && column_row == '0 && column_col == '0 && !last_element, "config error result carries data")

  `IAG_ASSERT_IMPLY(a_pad_zero, clk, rst, result_valid && is_padding, element_address == '0, "padding element has nonzero address")

  `IAG_ASSERT_NEXT(a_write_stalls, clk, rst, write_enable, !item_ready, "item accepted during geometry derivation")
endmodule

bind im2col_address_generator iag_checker u_iag_checker (
  .clk             (clk),
  .rst             (rst),
  .item_ready      (item.ready),
  .write_enable    (write_enable),
  .result_valid    (result.valid),
  .result_ready    (result.ready),
  .element_address (result.element_address),
  .is_padding      (result.is_padding),
  .column_row      (result.column_row),
  .column_col      (result.column_col),
  .last_element    (result.last_element),
  .config_error    (result.config_error)
);

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the im2col address generator. A short table of
// directed transactions covers reset geometry, padding, size clamping, zero
// stride and dilation, saturated output size and the configuration error.
// Random geometries and restart traffic follow under three
// valid/ready pressure profiles. Every result transaction is checked field by
// field against an in-bench model of the column-matrix walk.
// ----------------------------------------------------------------------------
module tb;
  import iag_pkg::*;

  // Block parameters, kept equal to the instance below.
  localparam int DIM_MAX  = 256;
  localparam int CHAN_MAX = 1024;
  localparam int KERN_MAX = 16;

  localparam int STALL_LIMIT  = 1000;  // cycles with no transaction at all
  localparam int DRAIN_CYCLES = 20;    // settle time once the last result is in
  localparam int PHASE_ITEMS  = 550;   // random transactions per pressure phase

  typedef enum logic [1:0] {ROW_WRITE, ROW_ITEM, ROW_KNOWN} row_kind_t;
  typedef enum logic [1:0] {GEO_SMALL, GEO_TIGHT, GEO_WILD} geo_mode_t;

  // One directed step: a register write, a predicted item, or an item whose
  // result is spelled out in the table.
  typedef struct packed {
    row_kind_t                kind;
    cfg_reg_t                 regsel;
    logic [CFG_DATA_W-1:0]    data;
    logic                     restart;
    result_t                  want;
  } row_t;

  // Results that can be read straight off the walk definition.
  localparam result_t EL_ORIGIN     = '{26'd0, 1'b0, 18'd0, 16'd0, 1'b0, 1'b0};
  localparam result_t EL_SECOND     = '{26'd1, 1'b0, 18'd0, 16'd1, 1'b0, 1'b0};
  localparam result_t EL_PAD_ORIGIN = '{26'd0, 1'b1, 18'd0, 16'd0, 1'b0, 1'b0};
  localparam result_t EL_ONLY       = '{26'd0, 1'b0, 18'd0, 16'd0, 1'b1, 1'b0};
  localparam result_t EL_CFG_ERR    = '{26'd0, 1'b0, 18'd0, 16'd0, 1'b0, 1'b1};

  localparam int SMOKE_LEN = 41;
  localparam row_t SMOKE_ROWS [SMOKE_LEN] = '{
    // reset geometry: 8x8 image, 3x3 kernel, 6x6 output
    '{ROW_KNOWN, REG_CHANNEL_COUNT,  16'h0000, 1'b0, EL_ORIGIN},
    '{ROW_KNOWN, REG_CHANNEL_COUNT,  16'h0000, 1'b0, EL_SECOND},
    '{ROW_KNOWN, REG_CHANNEL_COUNT,  16'h0000, 1'b1, EL_ORIGIN},
    '{ROW_ITEM,  REG_CHANNEL_COUNT,  16'h0000, 1'b0, EL_ORIGIN},
    // one pixel of padding each way: first element falls outside
    '{ROW_WRITE, REG_PAD_SIZES,      16'h0101, 1'b0, EL_ORIGIN},
    '{ROW_KNOWN, REG_CHANNEL_COUNT,  16'h0000, 1'b0, EL_PAD_ORIGIN},
    '{ROW_ITEM,  REG_CHANNEL_COUNT,  16'h0000, 1'b0, EL_ORIGIN},
    // kernel taller than padded image: config error, restart ignored
    '{ROW_WRITE, REG_KERNEL_HEIGHT,  16'h0010, 1'b0, EL_ORIGIN},
    '{ROW_KNOWN, REG_CHANNEL_COUNT,  16'h0000, 1'b1, EL_CFG_ERR},
    '{ROW_KNOWN, REG_CHANNEL_COUNT,  16'h0000, 1'b0, EL_CFG_ERR},
    // zero kernel height counts as one
    '{ROW_WRITE, REG_KERNEL_HEIGHT,  16'h0000, 1'b0, EL_ORIGIN},
    '{ROW_ITEM,  REG_CHANNEL_COUNT,  16'h0000, 1'b1, EL_ORIGIN},
    '{ROW_ITEM,  REG_CHANNEL_COUNT,  16'h0000, 1'b0, EL_ORIGIN},
    // 1x1 everything: a single-element walk, every element is last
    '{ROW_WRITE, REG_IMAGE_HEIGHT,   16'h0000, 1'b0, EL_ORIGIN},
    '{ROW_WRITE, REG_IMAGE_WIDTH,    16'h0000, 1'b0, EL_ORIGIN},
    '{ROW_WRITE, REG_KERNEL_WIDTH,   16'h0001, 1'b0, EL_ORIGIN},
    '{ROW_WRITE, REG_PAD_SIZES,      16'h0000, 1'b0, EL_ORIGIN},
    '{ROW_KNOWN, REG_CHANNEL_COUNT,  16'h0000, 1'b0, EL_ONLY},
    '{ROW_KNOWN, REG_CHANNEL_COUNT,  16'h0000, 1'b1, EL_ONLY},
    // all fields at their top: sizes clamp, zero dilation counts as one
    '{ROW_WRITE, REG_CHANNEL_COUNT,  16'hFFFF, 1'b0, EL_ORIGIN},
    '{ROW_WRITE, REG_IMAGE_HEIGHT,   16'h01FF, 1'b0, EL_ORIGIN},
    '{ROW_WRITE, REG_IMAGE_WIDTH,    16'h01FF, 1'b0, EL_ORIGIN},
    '{ROW_WRITE, REG_KERNEL_HEIGHT,  16'h001F, 1'b0, EL_ORIGIN},
    '{ROW_WRITE, REG_KERNEL_WIDTH,   16'h001F, 1'b0, EL_ORIGIN},
    '{ROW_WRITE, REG_PAD_SIZES,      16'hFFFF, 1'b0, EL_ORIGIN},
    '{ROW_WRITE, REG_STRIDE_SIZES,   16'hFFFF, 1'b0, EL_ORIGIN},
    '{ROW_WRITE, REG_DILATION_SIZES, 16'h0000, 1'b0, EL_ORIGIN},
    '{ROW_KNOWN, REG_CHANNEL_COUNT,  16'h0000, 1'b1, EL_PAD_ORIGIN},
    '{ROW_ITEM,  REG_CHANNEL_COUNT,  16'h0000, 1'b0, EL_ORIGIN},
    '{ROW_ITEM,  REG_CHANNEL_COUNT,  16'h0000, 1'b0, EL_ORIGIN},
    // widest dilation on a 16-tap kernel: config error
    '{ROW_WRITE, REG_STRIDE_SIZES,   16'h0000, 1'b0, EL_ORIGIN},
    '{ROW_WRITE, REG_DILATION_SIZES, 16'hFFFF, 1'b0, EL_ORIGIN},
    '{ROW_KNOWN, REG_CHANNEL_COUNT,  16'h0000, 1'b0, EL_CFG_ERR},
    // 1x1 kernel with full padding: output size saturates
    '{ROW_WRITE, REG_DILATION_SIZES, 16'h0101, 1'b0, EL_ORIGIN},
    '{ROW_WRITE, REG_KERNEL_HEIGHT,  16'h0001, 1'b0, EL_ORIGIN},
    '{ROW_WRITE, REG_KERNEL_WIDTH,   16'h0001, 1'b0, EL_ORIGIN},
    '{ROW_KNOWN, REG_CHANNEL_COUNT,  16'h0000, 1'b0, EL_PAD_ORIGIN},
    '{ROW_ITEM,  REG_CHANNEL_COUNT,  16'h0000, 1'b0, EL_ORIGIN},
    '{ROW_ITEM,  REG_CHANNEL_COUNT,  16'h0000, 1'b1, EL_ORIGIN},
    // zero channel count counts as one
    '{ROW_WRITE, REG_CHANNEL_COUNT,  16'h0000, 1'b0, EL_ORIGIN},
    '{ROW_ITEM,  REG_CHANNEL_COUNT,  16'h0000, 1'b0, EL_ORIGIN}
  };

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  write_enable;
  cfg_reg_t              register_index;
  logic [CFG_DATA_W-1:0] write_data;

  iag_item_if   item_ch ();
  iag_result_if elem_ch ();

  im2col_address_generator #(
    .MAX_DIM      (DIM_MAX),
    .MAX_CHANNELS (CHAN_MAX),
    .MAX_KERNEL   (KERN_MAX)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .item           (item_ch),
    .result         (elem_ch),
    .write_enable   (write_enable),
    .register_index (register_index),
    .write_data     (write_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Walk model: register copies, derived geometry and the walk position.
  // --------------------------------------------------------------------------
  logic [CH_W-1:0]       reg_chan;
  logic [IMG_W-1:0]      reg_img_h, reg_img_w;
  logic [KER_W-1:0]      reg_ker_h, reg_ker_w;
  logic [CFG_DATA_W-1:0] reg_pad, reg_stride, reg_dil;

  int eff_c, eff_h, eff_w, eff_kh, eff_kw;
  int pad_v, pad_h, str_v, str_h, dil_v, dil_h;
  int out_h, out_w;
  bit geom_err;

  int ch_i, kr_i, kc_i, or_i, oc_i;   // walk position
  int src_row, src_col, plane_base;   // kept in step with the position

  result_t pending_elements [$];      // predicted results, oldest first

  // Driver-side tag that travels with the item transaction.
  logic    row_known;
  result_t row_expect;

  int src_idle_pct, snk_idle_pct;
  int mismatches = 0;
  int elems_seen = 0;
  int pads_seen  = 0;
  int lasts_seen = 0;
  int errs_seen  = 0;
  int stall_cycles = 0;
  int items_sent, cfg_writes;

  function automatic int clamp_size(int v, int top);
    if (v == 0) return 1;
    return (v > top) ? top : v;
  endfunction

  function automatic int one_if_zero(int v);
    return (v == 0) ? 1 : v;
  endfunction

  // Output extent in one direction; 0 flags a non-positive size.
  function automatic int out_extent(int img, int pad, int k, int dil, int str);
    int num, o;
    num = img + 2 * pad - (dil * (k - 1) + 1);
    if (num < 0) return 0;
    o = num / str + 1;
    return (o > DIM_MAX) ? DIM_MAX : o;
  endfunction

  function automatic void refresh_source();
    plane_base = ch_i * eff_h * eff_w;
    src_row    = kr_i * dil_v + or_i * str_v - pad_v;
    src_col    = kc_i * dil_h + oc_i * str_h - pad_h;
  endfunction

  function automatic void walk_home();
    ch_i = 0;
    kr_i = 0;
    kc_i = 0;
    or_i = 0;
    oc_i = 0;
    refresh_source();
  endfunction

  function automatic void derive_geometry();
    eff_c    = clamp_size(int'(reg_chan), CHAN_MAX);
    eff_h    = clamp_size(int'(reg_img_h), DIM_MAX);
    eff_w    = clamp_size(int'(reg_img_w), DIM_MAX);
    eff_kh   = clamp_size(int'(reg_ker_h), KERN_MAX);
    eff_kw   = clamp_size(int'(reg_ker_w), KERN_MAX);
    pad_v    = int'(reg_pad[15:8]);
    pad_h    = int'(reg_pad[7:0]);
    str_v    = one_if_zero(int'(reg_stride[15:8]));
    str_h    = one_if_zero(int'(reg_stride[7:0]));
    dil_v    = one_if_zero(int'(reg_dil[15:8]));
    dil_h    = one_if_zero(int'(reg_dil[7:0]));
    out_h    = out_extent(eff_h, pad_v, eff_kh, dil_v, str_v);
    out_w    = out_extent(eff_w, pad_h, eff_kw, dil_h, str_h);
    geom_err = (out_h == 0) || (out_w == 0);
    walk_home();
  endfunction

  function automatic void mirror_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_CHANNEL_COUNT:  reg_chan   = d[CH_W-1:0];
      REG_IMAGE_HEIGHT:   reg_img_h  = d[IMG_W-1:0];
      REG_IMAGE_WIDTH:    reg_img_w  = d[IMG_W-1:0];
      REG_KERNEL_HEIGHT:  reg_ker_h  = d[KER_W-1:0];
      REG_KERNEL_WIDTH:   reg_ker_w  = d[KER_W-1:0];
      REG_PAD_SIZES:      reg_pad    = d;
      REG_STRIDE_SIZES:   reg_stride = d;
      REG_DILATION_SIZES: reg_dil    = d;
      default: ;
    endcase
    derive_geometry();
  endfunction

  // Element at the current position, then advance (innermost: output column).
  function automatic result_t predict_element(bit restart);
    result_t el;
    bit      outside;
    int      addr;
    el = '0;
    if (geom_err) begin
      // walk holds, restart has no effect
      el.config_error = 1'b1;
      return el;
    end
    if (restart) walk_home();
    outside = (src_row < 0) || (src_row >= eff_h) || (src_col < 0) || (src_col >= eff_w);
    addr    = outside ? 0 : plane_base + src_row * eff_w + src_col;
    el.element_address = ADDR_W'(addr);
    el.is_padding      = outside;
    el.column_row      = CROW_W'((ch_i * eff_kh + kr_i) * eff_kw + kc_i);
    el.column_col      = CCOL_W'(or_i * out_w + oc_i);
    el.last_element    = (ch_i + 1 == eff_c) && (kr_i + 1 == eff_kh) &&
                         (kc_i + 1 == eff_kw) && (or_i + 1 == out_h) && (oc_i + 1 == out_w);
    if (++oc_i >= out_w) begin
      oc_i = 0;
      if (++or_i >= out_h) begin
        or_i = 0;
        if (++kc_i >= eff_kw) begin
          kc_i = 0;
          if (++kr_i >= eff_kh) begin
            kr_i = 0;
            if (++ch_i >= eff_c) ch_i = 0;
          end
        end
      end
    end
    refresh_source();
    return el;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, scoreboard and watchdog.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    elem_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Input and output transactions are handled in one process so that a
  // prediction is always queued before the matching result can be popped.
  always @(posedge clk) begin : scoreboard
    result_t want;
    bit      moved;
    if (!rst) begin
      moved = 1'b0;
      if (item_ch.valid && item_ch.ready) begin
        want = predict_element(item_ch.restart);
        // table rows with a spelled-out result override the model, which
        // still steps so the walk stays in line
        if (row_known) want = row_expect;
        pending_elements.push_back(want);
        moved = 1'b1;
      end
      if (elem_ch.valid && elem_ch.ready) begin
        moved = 1'b1;
        elems_seen++;
        pads_seen  += elem_ch.is_padding;
        lasts_seen += elem_ch.last_element;
        errs_seen  += elem_ch.config_error;
        if (pending_elements.size() == 0) begin
          $error("result transaction with no element outstanding (address 0x%0h)",
                 elem_ch.element_address);
          mismatches++;
        end else begin
          want = pending_elements.pop_front();
          check_field("element_address", want.element_address, elem_ch.element_address);
          check_field("is_padding", want.is_padding, elem_ch.is_padding);
          check_field("column_row", want.column_row, elem_ch.column_row);
          check_field("column_col", want.column_col, elem_ch.column_col);
          check_field("last_element", want.last_element, elem_ch.last_element);
          check_field("config_error", want.config_error, elem_ch.config_error);
        end
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d elements outstanding",
                 STALL_LIMIT, pending_elements.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Item side.
  // --------------------------------------------------------------------------

  // Present one item and hold it until the block takes it. Idle cycles ahead
  // of it follow src_idle_pct; with no idle, valid simply stays high.
  task automatic send_item(bit restart, bit known, result_t want);
    while ($urandom_range(99) < src_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid   <= 1'b1;
    item_ch.restart <= restart;
    row_known       <= known;
    row_expect      <= want;
    do @(posedge clk); while (!item_ch.ready);
    items_sent++;
  endtask

  // Stop sending and wait until every predicted element has come back.
  // The queue is polled on the falling edge, clear of the scoreboard update.
  task automatic drain();
    item_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_elements.size() != 0);
    @(posedge clk);
  endtask

  // One write lands at the next rising edge; back-to-back writes are fine.
  task automatic cfg_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
    write_enable   <= 1'b1;
    register_index <= idx;
    write_data     <= d;
    mirror_write(idx, d);
    cfg_writes++;
    @(posedge clk);
  endtask

  // Register value for a random geometry. Small geometries keep walks short
  // so wrap and last_element come up; tight ones often yield a config error;
  // wild ones hit every bit, the extremes and the clamping paths.
  function automatic logic [CFG_DATA_W-1:0] geometry_value(cfg_reg_t idx, geo_mode_t mode);
    logic [CFG_DATA_W-1:0] v;
    if (mode == GEO_WILD) begin
      case ($urandom_range(3))
        0:       v = '0;
        1:       v = '1;
        default: v = CFG_DATA_W'($urandom_range(65535));
      endcase
      return v;
    end
    case (idx)
      REG_CHANNEL_COUNT:  v = CFG_DATA_W'($urandom_range(2));
      REG_IMAGE_HEIGHT,
      REG_IMAGE_WIDTH:    v = CFG_DATA_W'((mode == GEO_TIGHT) ? $urandom_range(1, 4)
                                                              : $urandom_range(7));
      REG_KERNEL_HEIGHT,
      REG_KERNEL_WIDTH:   v = CFG_DATA_W'((mode == GEO_TIGHT) ? $urandom_range(2, 6)
                                                              : $urandom_range(4));
      REG_PAD_SIZES:      v = {8'($urandom_range(1)), 8'($urandom_range(1))};
      REG_STRIDE_SIZES:   v = {8'($urandom_range(3)), 8'($urandom_range(3))};
      REG_DILATION_SIZES: v = {8'($urandom_range(2)), 8'($urandom_range(2))};
      default:            v = '0;
    endcase
    return v;
  endfunction

  // Quiesce, then rewrite a random subset of registers.
  task automatic reconfigure(geo_mode_t mode);
    cfg_reg_t idx;
    drain();
    idx = idx.first();
    repeat (8) begin
      if ($urandom_range(3) != 0) cfg_write(idx, geometry_value(idx, mode));
      idx = idx.next();
    end
    write_enable <= 1'b0;
  endtask

  initial begin : stimulus
    row_t      row;
    bit        in_cfg, paused;
    int        phase_items, burst;
    geo_mode_t mode;

    rst            <= 1'b1;
    item_ch.valid  <= 1'b0;
    item_ch.restart <= 1'b0;
    write_enable   <= 1'b0;
    register_index <= REG_CHANNEL_COUNT;
    write_data     <= '0;
    row_known      <= 1'b0;
    row_expect     <= '0;
    items_sent = 0;
    cfg_writes = 0;
    src_idle_pct = 6;
    snk_idle_pct = 64;

    // model starts from the reset register values
    reg_chan   = RST_CHANNEL_COUNT;
    reg_img_h  = RST_IMAGE_HEIGHT;
    reg_img_w  = RST_IMAGE_WIDTH;
    reg_ker_h  = RST_KERNEL_HEIGHT;
    reg_ker_w  = RST_KERNEL_WIDTH;
    reg_pad    = RST_PAD_SIZES;
    reg_stride = RST_STRIDE_SIZES;
    reg_dil    = RST_DILATION_SIZES;
    derive_geometry();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed table. A run of write rows is issued back to back once the
    // block has gone quiet; write_enable drops with the next item.
    in_cfg = 1'b0;
    for (int i = 0; i < SMOKE_LEN; i++) begin
      row = SMOKE_ROWS[i];
      if (row.kind == ROW_WRITE) begin
        if (!in_cfg) drain();
        in_cfg = 1'b1;
        cfg_write(row.regsel, row.data);
      end else begin
        if (in_cfg) write_enable <= 1'b0;
        in_cfg = 1'b0;
        send_item(row.restart, row.kind == ROW_KNOWN, row.want);
      end
    end

    // Random part: receiver-heavy idling, then sender-heavy, then none.
    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 64 : 0;
      snk_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 6 : 0;
      phase_items  = 0;
      paused       = 1'b0;
      while (phase_items < PHASE_ITEMS) begin
        case ($urandom_range(9))
          0:       mode = GEO_WILD;
          1, 2:    mode = GEO_TIGHT;
          default: mode = GEO_SMALL;
        endcase
        reconfigure(mode);
        burst = $urandom_range(30, 90);
        for (int k = 0; k < burst && phase_items < PHASE_ITEMS; k++) begin
          // mid-phase hold-off with no write: the pipe runs dry, then resumes
          if (!paused && phase_items >= PHASE_ITEMS / 2) begin
            drain();
            paused = 1'b1;
          end
          send_item($urandom_range(99) < 4, 1'b0, '0);
          phase_items++;
        end
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d elements from %0d items across %0d register writes.",
             elems_seen, items_sent, cfg_writes);
    $display("Seen: %0d padding, %0d last-element, %0d config-error transactions.",
             pads_seen, lasts_seen, errs_seen);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
